>>> hdl/aavr_pkg.sv
// shared types, constants and arithmetic helpers of the axis-angle rotation unit
`timescale 1ns / 1ps

package aavr_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;

   localparam int RT_STEPS  = 32;
   localparam int DIV_STEPS = 32;
   localparam int HRN_RNDS  = 3;

   // stage map of the pipeline
   localparam int ST_SQR  = 0;
   localparam int ST_SUM  = ST_SQR + 1;
   localparam int ST_NRM1 = ST_SUM + 1;
   localparam int ST_NRM2 = ST_NRM1 + 1;
   localparam int ST_RT0  = ST_NRM2 + 1;
   localparam int ST_DSET = ST_RT0 + RT_STEPS;
   localparam int ST_DV0  = ST_DSET + 1;
   localparam int ST_CLMP = ST_DV0 + DIV_STEPS;
   localparam int ST_PH   = ST_CLMP + 1;
   localparam int ST_X    = ST_PH + 1;
   localparam int ST_X2   = ST_X + 1;
   localparam int ST_H0   = ST_X2 + 1;
   localparam int ST_HR0  = ST_H0 + 1;
   localparam int ST_TF   = ST_HR0 + 2 * HRN_RNDS;
   localparam int ST_FOLD = ST_TF + 1;
   localparam int ST_R1   = ST_FOLD + 1;
   localparam int ST_R2   = ST_R1 + 1;
   localparam int ST_R3   = ST_R2 + 1;
   localparam int ST_OUT  = ST_R3 + 1;
   localparam int NSTAGE  = ST_OUT + 1;

   localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF   = 64'd1 << 29;
   localparam logic [63:0] INV_TWO_PI = 64'd683565276;
   localparam logic [63:0] HALF_PI    = 64'd1686629713;

   // reciprocals for exact floor division of values below 2^30
   localparam logic [31:0] RCP_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
   localparam logic [31:0] RCP_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
   localparam logic [31:0] RCP_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
   localparam logic [31:0] RCP_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
   localparam logic [31:0] RCP_90 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
   localparam logic [31:0] RCP_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
   localparam logic [31:0] RCP_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
   localparam logic [31:0] RCP_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);

   localparam int unsigned SH_72 = 37;
   localparam int unsigned SH_90 = 37;

   localparam logic [31:0] RCP_SIN [HRN_RNDS] = '{RCP_42, RCP_20, RCP_6};
   localparam int unsigned SH_SIN  [HRN_RNDS] = '{36, 35, 33};
   localparam logic [31:0] RCP_COS [HRN_RNDS] = '{RCP_56, RCP_30, RCP_12};
   localparam int unsigned SH_COS  [HRN_RNDS] = '{36, 35, 34};

   typedef struct packed {
      logic             valid;
      logic [2:0][31:0] vec;
      logic [2:0][31:0] wvec;
      logic [2:0][63:0] sqp;
      logic             zero;
      logic [63:0]      sq;
      logic [4:0]       k;
      logic [63:0]      root;
      logic [31:0]      rt;
      logic [61:0]      prod;
      logic [2:0][31:0] prem;
      logic [2:0][31:0] plow;
      logic [2:0][31:0] quo;
      logic [2:0][31:0] axis;
      logic [1:0]       quad;
      logic             swap;
      logic [29:0]      fo;
      logic [29:0]      x;
      logic [29:0]      x2;
      logic [30:0]      ts;
      logic [30:0]      tc;
      logic [29:0]      ps;
      logic [29:0]      pc;
      logic [30:0]      s0;
      logic [30:0]      c0;
      logic [31:0]      sn;
      logic [31:0]      cs;
      logic [8:0][32:0] mva;
      logic [34:0]      d;
      logic [2:0][33:0] c;
      logic [32:0]      omc;
      logic [35:0]      t;
      logic [2:0][33:0] mvc;
      logic [2:0][34:0] mcs;
      logic [2:0][35:0] mta;
      logic [2:0][31:0] rot;
   } pipe_type;

   // p * q / 2^30 rounded half away from zero
   function automatic logic signed [37:0] mul_q30(input logic signed [35:0] p,
                                                  input logic signed [32:0] q);
      logic        neg;
      logic [35:0] m;
      logic [32:0] n;
      logic [68:0] pr;
      logic [37:0] r;
      neg = p[35] ^ q[32];
      m   = p[35] ? 36'(-p) : 36'(p);
      n   = q[32] ? 33'(-q) : 33'(q);
      pr  = 69'(m) * 69'(n) + 69'(Q30_HALF);
      r   = 38'(pr >> 30);
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // floor(y / n) through the reciprocal m = ceil(2^s / n)
   function automatic logic [29:0] div_const(input logic [29:0] y,
                                             input logic [31:0] m,
                                             input int unsigned s);
      logic [61:0] pr;
      pr = 62'(y) * 62'(m);
      return 30'(pr >> s);
   endfunction

   function automatic logic [31:0] abs_word(input logic [31:0] w);
      return w[31] ? 32'(-w) : w;
   endfunction

endpackage

>>> hdl/axis_angle_vector_rotation_unit.sv
// top level: fully pipelined rodrigues rotation of a q16.16 vector
`timescale 1ns / 1ps

// channel   ports                                   direction  handshake
// request   req_vec_x/y/z, req_axis_x/y/z           in         start & !busy
// response  rsp_rot_x/y/z                           out        rsp_valid strobe
//
// one transaction enters per cycle; its result strobes on rsp_valid once it has passed
// every stage register; most of the depth comes from the 32-step square root
// and the 32-step quotient pipelines, one bit per stage
// busy is held low: the pipeline never stalls since the receiver takes every strobe
// synchronous reset clears only the valid bits that travel with each stage

module axis_angle_vector_rotation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_vec_x,
   input  logic [31:0] req_vec_y,
   input  logic [31:0] req_vec_z,
   input  logic [31:0] req_axis_x,
   input  logic [31:0] req_axis_y,
   input  logic [31:0] req_axis_z,
   output logic        rsp_valid,
   output logic [31:0] rsp_rot_x,
   output logic [31:0] rsp_rot_y,
   output logic [31:0] rsp_rot_z
);

   aavr_pkg::pipe_type pipe_ff [aavr_pkg::NSTAGE];
   aavr_pkg::pipe_type pipe_in [aavr_pkg::NSTAGE];

   assign busy = 1'b0;

   // squares of the rotation vector components
   always_comb begin : sqr_stage
      logic [31:0] mag;
      pipe_in[aavr_pkg::ST_SQR] = '0;
      pipe_in[aavr_pkg::ST_SQR].valid = start & ~busy;
      pipe_in[aavr_pkg::ST_SQR].vec   = {req_vec_z, req_vec_y, req_vec_x};
      pipe_in[aavr_pkg::ST_SQR].wvec  = {req_axis_z, req_axis_y, req_axis_x};
      for (int i = 0; i < 3; i++) begin
         mag = aavr_pkg::abs_word(pipe_in[aavr_pkg::ST_SQR].wvec[i]);
         pipe_in[aavr_pkg::ST_SQR].sqp[i] = 64'(mag) * 64'(mag);
      end
   end

   always_comb begin : sum_stage
      pipe_in[aavr_pkg::ST_SUM] = pipe_ff[aavr_pkg::ST_SUM - 1];
      pipe_in[aavr_pkg::ST_SUM].sq = pipe_ff[aavr_pkg::ST_SUM - 1].sqp[0]
                                   + pipe_ff[aavr_pkg::ST_SUM - 1].sqp[1]
                                   + pipe_ff[aavr_pkg::ST_SUM - 1].sqp[2];
      // zero rotation vector means pass-through
      pipe_in[aavr_pkg::ST_SUM].zero = (pipe_ff[aavr_pkg::ST_SUM - 1].sqp[0]
                                      | pipe_ff[aavr_pkg::ST_SUM - 1].sqp[1]
                                      | pipe_ff[aavr_pkg::ST_SUM - 1].sqp[2]) == 64'd0;
   end

   // normalize so bit 62 or 63 is set, shifting by even counts, in this and the next stage
   always_comb begin : nrm1_stage
      logic [63:0] s;
      logic [4:0]  kk;
      pipe_in[aavr_pkg::ST_NRM1] = pipe_ff[aavr_pkg::ST_NRM1 - 1];
      s  = pipe_ff[aavr_pkg::ST_NRM1 - 1].sq;
      kk = 5'd0;
      if (s[63:32] == 32'd0) begin
         s  = s << 32;
         kk = kk + 5'd16;
      end
      if (s[63:48] == 16'd0) begin
         s  = s << 16;
         kk = kk + 5'd8;
      end
      if (s[63:56] == 8'd0) begin
         s  = s << 8;
         kk = kk + 5'd4;
      end
      pipe_in[aavr_pkg::ST_NRM1].sq = s;
      pipe_in[aavr_pkg::ST_NRM1].k  = kk;
   end

   always_comb begin : nrm2_stage
      logic [63:0] s;
      logic [4:0]  kk;
      pipe_in[aavr_pkg::ST_NRM2] = pipe_ff[aavr_pkg::ST_NRM2 - 1];
      s  = pipe_ff[aavr_pkg::ST_NRM2 - 1].sq;
      kk = pipe_ff[aavr_pkg::ST_NRM2 - 1].k;
      if (s[63:60] == 4'd0) begin
         s  = s << 4;
         kk = kk + 5'd2;
      end
      if (s[63:62] == 2'd0) begin
         s  = s << 2;
         kk = kk + 5'd1;
      end
      pipe_in[aavr_pkg::ST_NRM2].sq   = s;
      pipe_in[aavr_pkg::ST_NRM2].k    = kk;
      pipe_in[aavr_pkg::ST_NRM2].root = 64'd0;
   end

   // integer square root, one result bit per stage; sq carries the remainder
   for (genvar j = 0; j < aavr_pkg::RT_STEPS; j++) begin : g_rt
      localparam int S = aavr_pkg::ST_RT0 + j;
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
      always_comb begin : rt_stage
         logic [63:0] tmp;
         pipe_in[S] = pipe_ff[S - 1];
         tmp = pipe_ff[S - 1].root + BIT;
         if (pipe_ff[S - 1].sq >= tmp) begin
            pipe_in[S].sq   = pipe_ff[S - 1].sq - tmp;
            pipe_in[S].root = (pipe_ff[S - 1].root >> 1) + BIT;
         end else begin
            pipe_in[S].root = pipe_ff[S - 1].root >> 1;
         end
      end
   end

   // dividend setup for the axis and angle product in turns
   always_comb begin : dset_stage
      logic [31:0] r;
      logic [63:0] num;
      pipe_in[aavr_pkg::ST_DSET] = pipe_ff[aavr_pkg::ST_DSET - 1];
      r = pipe_ff[aavr_pkg::ST_DSET - 1].root[31:0];
      pipe_in[aavr_pkg::ST_DSET].rt   = r;
      pipe_in[aavr_pkg::ST_DSET].prod = 62'(64'(r) * aavr_pkg::INV_TWO_PI);
      for (int i = 0; i < 3; i++) begin
         num = (64'(aavr_pkg::abs_word(pipe_ff[aavr_pkg::ST_DSET - 1].wvec[i]))
                << (pipe_ff[aavr_pkg::ST_DSET - 1].k + 6'd30)) + 64'(r >> 1);
         pipe_in[aavr_pkg::ST_DSET].prem[i] = num[63:32];
         pipe_in[aavr_pkg::ST_DSET].plow[i] = num[31:0];
         pipe_in[aavr_pkg::ST_DSET].quo[i]  = 32'd0;
      end
   end

   // restoring division, one quotient bit per stage in three lanes
   for (genvar j = 0; j < aavr_pkg::DIV_STEPS; j++) begin : g_dv
      localparam int S = aavr_pkg::ST_DV0 + j;
      always_comb begin : dv_stage
         logic [32:0] cat;
         logic        qb;
         pipe_in[S] = pipe_ff[S - 1];
         for (int i = 0; i < 3; i++) begin
            cat = {pipe_ff[S - 1].prem[i], pipe_ff[S - 1].plow[i][31]};
            qb  = cat >= {1'b0, pipe_ff[S - 1].rt};
            pipe_in[S].prem[i] = qb ? 32'(cat - {1'b0, pipe_ff[S - 1].rt}) : cat[31:0];
            pipe_in[S].plow[i] = pipe_ff[S - 1].plow[i] << 1;
            pipe_in[S].quo[i]  = {pipe_ff[S - 1].quo[i][30:0], qb};
         end
      end
   end

   // clamp to unit magnitude and restore the sign
   always_comb begin : clmp_stage
      logic [31:0] q;
      pipe_in[aavr_pkg::ST_CLMP] = pipe_ff[aavr_pkg::ST_CLMP - 1];
      for (int i = 0; i < 3; i++) begin
         q = pipe_ff[aavr_pkg::ST_CLMP - 1].quo[i];
         if (q > 32'(aavr_pkg::Q30_ONE)) begin
            q = 32'(aavr_pkg::Q30_ONE);
         end
         pipe_in[aavr_pkg::ST_CLMP].axis[i] =
            pipe_ff[aavr_pkg::ST_CLMP - 1].wvec[i][31] ? 32'(-q) : q;
      end
   end

   // phase in turns, quadrant and octant fold
   always_comb begin : ph_stage
      logic [5:0]  sh;
      logic [31:0] phase;
      pipe_in[aavr_pkg::ST_PH] = pipe_ff[aavr_pkg::ST_PH - 1];
      sh    = 6'(aavr_pkg::FRAC_BITS) + 6'(pipe_ff[aavr_pkg::ST_PH - 1].k);
      phase = 32'(pipe_ff[aavr_pkg::ST_PH - 1].prod >> sh);
      pipe_in[aavr_pkg::ST_PH].quad = phase[31:30];
      pipe_in[aavr_pkg::ST_PH].swap = phase[29];
      pipe_in[aavr_pkg::ST_PH].fo   =
         phase[29] ? 30'(aavr_pkg::Q30_ONE - 64'(phase[29:0])) : phase[29:0];
   end

   always_comb begin : x_stage
      logic [61:0] pr;
      pipe_in[aavr_pkg::ST_X] = pipe_ff[aavr_pkg::ST_X - 1];
      pr = 62'(pipe_ff[aavr_pkg::ST_X - 1].fo) * 62'(aavr_pkg::HALF_PI)
         + 62'(aavr_pkg::Q30_HALF);
      pipe_in[aavr_pkg::ST_X].x = 30'(pr >> 30);
   end

   always_comb begin : x2_stage
      logic [59:0] pr;
      pipe_in[aavr_pkg::ST_X2] = pipe_ff[aavr_pkg::ST_X2 - 1];
      pr = 60'(pipe_ff[aavr_pkg::ST_X2 - 1].x) * 60'(pipe_ff[aavr_pkg::ST_X2 - 1].x)
         + 60'(aavr_pkg::Q30_HALF);
      pipe_in[aavr_pkg::ST_X2].x2 = 30'(pr >> 30);
   end

   // innermost horner terms of the sine and cosine series
   always_comb begin : h0_stage
      pipe_in[aavr_pkg::ST_H0] = pipe_ff[aavr_pkg::ST_H0 - 1];
      pipe_in[aavr_pkg::ST_H0].ts = 31'(aavr_pkg::Q30_ONE)
         - 31'(aavr_pkg::div_const(pipe_ff[aavr_pkg::ST_H0 - 1].x2,
                                   aavr_pkg::RCP_72, aavr_pkg::SH_72));
      pipe_in[aavr_pkg::ST_H0].tc = 31'(aavr_pkg::Q30_ONE)
         - 31'(aavr_pkg::div_const(pipe_ff[aavr_pkg::ST_H0 - 1].x2,
                                   aavr_pkg::RCP_90, aavr_pkg::SH_90));
   end

   // each horner round: product stage, then divide-and-subtract stage
   for (genvar j = 0; j < aavr_pkg::HRN_RNDS; j++) begin : g_hr
      localparam int SA = aavr_pkg::ST_HR0 + 2 * j;
      localparam int SB = SA + 1;
      always_comb begin : hra_stage
         pipe_in[SA] = pipe_ff[SA - 1];
         pipe_in[SA].ps = 30'((61'(pipe_ff[SA - 1].x2) * 61'(pipe_ff[SA - 1].ts)) >> 30);
         pipe_in[SA].pc = 30'((61'(pipe_ff[SA - 1].x2) * 61'(pipe_ff[SA - 1].tc)) >> 30);
      end
      always_comb begin : hrb_stage
         pipe_in[SB] = pipe_ff[SB - 1];
         pipe_in[SB].ts = 31'(aavr_pkg::Q30_ONE)
            - 31'(aavr_pkg::div_const(pipe_ff[SB - 1].ps,
                                      aavr_pkg::RCP_SIN[j], aavr_pkg::SH_SIN[j]));
         pipe_in[SB].tc = 31'(aavr_pkg::Q30_ONE)
            - 31'(aavr_pkg::div_const(pipe_ff[SB - 1].pc,
                                      aavr_pkg::RCP_COS[j], aavr_pkg::SH_COS[j]));
      end
   end

   always_comb begin : tf_stage
      pipe_in[aavr_pkg::ST_TF] = pipe_ff[aavr_pkg::ST_TF - 1];
      pipe_in[aavr_pkg::ST_TF].s0 = 31'((61'(pipe_ff[aavr_pkg::ST_TF - 1].x)
                                       * 61'(pipe_ff[aavr_pkg::ST_TF - 1].ts)) >> 30);
      pipe_in[aavr_pkg::ST_TF].c0 = 31'(aavr_pkg::Q30_ONE)
         - 31'((61'(pipe_ff[aavr_pkg::ST_TF - 1].x2)
                * 61'(pipe_ff[aavr_pkg::ST_TF - 1].tc)) >> 31);
   end

   // quadrant mapping and the nine axis products
   always_comb begin : fold_stage
      logic [31:0] s;
      logic [31:0] c;
      pipe_in[aavr_pkg::ST_FOLD] = pipe_ff[aavr_pkg::ST_FOLD - 1];
      if (pipe_ff[aavr_pkg::ST_FOLD - 1].swap) begin
         s = {1'b0, pipe_ff[aavr_pkg::ST_FOLD - 1].c0};
         c = {1'b0, pipe_ff[aavr_pkg::ST_FOLD - 1].s0};
      end else begin
         s = {1'b0, pipe_ff[aavr_pkg::ST_FOLD - 1].s0};
         c = {1'b0, pipe_ff[aavr_pkg::ST_FOLD - 1].c0};
      end
      case (pipe_ff[aavr_pkg::ST_FOLD - 1].quad)
         2'd0: begin
            pipe_in[aavr_pkg::ST_FOLD].sn = s;
            pipe_in[aavr_pkg::ST_FOLD].cs = c;
         end
         2'd1: begin
            pipe_in[aavr_pkg::ST_FOLD].sn = c;
            pipe_in[aavr_pkg::ST_FOLD].cs = -s;
         end
         2'd2: begin
            pipe_in[aavr_pkg::ST_FOLD].sn = -s;
            pipe_in[aavr_pkg::ST_FOLD].cs = -c;
         end
         default: begin
            pipe_in[aavr_pkg::ST_FOLD].sn = -c;
            pipe_in[aavr_pkg::ST_FOLD].cs = s;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pipe_in[aavr_pkg::ST_FOLD].mva[i * 3 + j] = 33'(aavr_pkg::mul_q30(
               36'($signed(pipe_ff[aavr_pkg::ST_FOLD - 1].vec[i])),
               33'($signed(pipe_ff[aavr_pkg::ST_FOLD - 1].axis[j]))));
         end
      end
   end

   // dot and cross products, one minus cosine
   always_comb begin : r1_stage
      pipe_in[aavr_pkg::ST_R1] = pipe_ff[aavr_pkg::ST_R1 - 1];
      pipe_in[aavr_pkg::ST_R1].d = 35'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[0]))
                                 + 35'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[4]))
                                 + 35'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[8]));
      pipe_in[aavr_pkg::ST_R1].c[0] = 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[7]))
                                    - 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[5]));
      pipe_in[aavr_pkg::ST_R1].c[1] = 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[2]))
                                    - 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[6]));
      pipe_in[aavr_pkg::ST_R1].c[2] = 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[3]))
                                    - 34'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].mva[1]));
      pipe_in[aavr_pkg::ST_R1].omc = 33'(aavr_pkg::Q30_ONE)
                                   - 33'($signed(pipe_ff[aavr_pkg::ST_R1 - 1].cs));
   end

   always_comb begin : r2_stage
      pipe_in[aavr_pkg::ST_R2] = pipe_ff[aavr_pkg::ST_R2 - 1];
      pipe_in[aavr_pkg::ST_R2].t = 36'(aavr_pkg::mul_q30(
         36'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].d)),
         33'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].omc))));
      for (int i = 0; i < 3; i++) begin
         pipe_in[aavr_pkg::ST_R2].mvc[i] = 34'(aavr_pkg::mul_q30(
            36'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].vec[i])),
            33'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].cs))));
         pipe_in[aavr_pkg::ST_R2].mcs[i] = 35'(aavr_pkg::mul_q30(
            36'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].c[i])),
            33'($signed(pipe_ff[aavr_pkg::ST_R2 - 1].sn))));
      end
   end

   always_comb begin : r3_stage
      pipe_in[aavr_pkg::ST_R3] = pipe_ff[aavr_pkg::ST_R3 - 1];
      for (int i = 0; i < 3; i++) begin
         pipe_in[aavr_pkg::ST_R3].mta[i] = 36'(aavr_pkg::mul_q30(
            $signed(pipe_ff[aavr_pkg::ST_R3 - 1].t),
            33'($signed(pipe_ff[aavr_pkg::ST_R3 - 1].axis[i]))));
      end
   end

   // final sum, saturation and zero-axis bypass
   always_comb begin : out_stage
      logic signed [37:0] s;
      pipe_in[aavr_pkg::ST_OUT] = pipe_ff[aavr_pkg::ST_OUT - 1];
      for (int i = 0; i < 3; i++) begin
         s = 38'($signed(pipe_ff[aavr_pkg::ST_OUT - 1].mta[i]))
           + 38'($signed(pipe_ff[aavr_pkg::ST_OUT - 1].mvc[i]))
           + 38'($signed(pipe_ff[aavr_pkg::ST_OUT - 1].mcs[i]));
         if (pipe_ff[aavr_pkg::ST_OUT - 1].zero) begin
            pipe_in[aavr_pkg::ST_OUT].rot[i] = pipe_ff[aavr_pkg::ST_OUT - 1].vec[i];
         end else if (s > 38'sh0007fffffff) begin
            pipe_in[aavr_pkg::ST_OUT].rot[i] = 32'h7fff_ffff;
         end else if (s < -38'sh00080000000) begin
            pipe_in[aavr_pkg::ST_OUT].rot[i] = 32'h8000_0000;
         end else begin
            pipe_in[aavr_pkg::ST_OUT].rot[i] = s[31:0];
         end
      end
   end

   // stage registers; only the valid bits are reset
   always_ff @(posedge clock) begin : stage_regs
      aavr_pkg::pipe_type nxt;
      for (int s = 0; s < aavr_pkg::NSTAGE; s++) begin
         nxt = pipe_in[s];
         if (reset) begin
            nxt.valid = 1'b0;
         end
         pipe_ff[s] <= nxt;
      end
   end

   assign rsp_valid = pipe_ff[aavr_pkg::ST_OUT].valid;
   assign rsp_rot_x = pipe_ff[aavr_pkg::ST_OUT].rot[0];
   assign rsp_rot_y = pipe_ff[aavr_pkg::ST_OUT].rot[1];
   assign rsp_rot_z = pipe_ff[aavr_pkg::ST_OUT].rot[2];

endmodule
